// File: rtl/core/lnf_pkg.sv
// Shared types and constants for the two-point line normal form block.
// Used by every module under rtl/core; depends on nothing.
package lnf_pkg;

    localparam int COORD_BITS   = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int DIST_BITS    = 16;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * COORD_BITS;
    localparam int CROSS_W      = 2 * COORD_BITS + 1;
    localparam int CMAG_W       = 2 * COORD_BITS;
    localparam int L2_W         = 2 * COORD_BITS + 1;
    localparam int RSQ_W        = 2 * CMAG_W;
    localparam int DIST_W       = 72;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_SHIFT = 40 - COORD_BITS;
    localparam int CORDIC_W     = 44;
    localparam int Z_W          = 34;
    localparam int ANGLE_SHIFT  = 32 - ANGLE_BITS;

    localparam int FRONT_LAT    = 3;
    localparam int DIST_LAT     = COORD_BITS + 2;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int TOTAL_LAT    = FRONT_LAT + CORDIC_LAT + 1;
    localparam int DIST_MAX     = 46341;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
    } lnf_item_t;

    typedef struct packed {
        logic [DIST_BITS-1:0]          distance;
        logic signed [ANGLE_BITS-1:0]  normal_angle;
        logic                          degenerate;
    } lnf_result_t;

    typedef struct packed {
        logic [CMAG_W-1:0]         cmag;
        logic [L2_W-1:0]           len2;
        logic signed [DIFF_W-1:0]  vx;
        logic signed [DIFF_W-1:0]  vy;
        logic                      degen;
    } lnf_geom_t;

endpackage

// File: rtl/core/lnf_front.sv
// Front end: differences, cross product, squared length and normal vector.
// Three register stages; depends on lnf_pkg.
module lnf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lnf_pkg::lnf_item_t item,
    output logic              geom_valid,
    output lnf_pkg::lnf_geom_t geom
);
    import lnf_pkg::*;

    logic [2:0] valid_reg;

    // stage A
    logic signed [DIFF_W-1:0] dx_a_reg, dy_a_reg;
    logic signed [PROD_W-1:0] p0_a_reg, p1_a_reg;
    logic                     degen_a_reg;
    // stage B
    logic signed [DIFF_W-1:0]  dx_b_reg, dy_b_reg;
    logic signed [CROSS_W-1:0] cross_b_reg;
    logic [PROD_W-1:0]         sqx_b_reg, sqy_b_reg;
    logic                      degen_b_reg;
    // stage C
    lnf_geom_t geom_reg;

    logic signed [PROD_W-1:0]   p0_next, p1_next;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    logic                       cneg, cpos;
    logic [CROSS_W-1:0]         cabs;
    lnf_geom_t                  geom_next;

    always_comb
    begin
        p0_next  = item.first_x * item.second_y;
        p1_next  = item.first_y * item.second_x;
        sqx_full = dx_a_reg * dx_a_reg;
        sqy_full = dy_a_reg * dy_a_reg;
        cneg     = cross_b_reg[CROSS_W-1];
        cpos     = !cneg && (cross_b_reg != '0);
        cabs     = cneg ? CROSS_W'(-cross_b_reg) : CROSS_W'(cross_b_reg);
        geom_next.cmag  = cabs[CMAG_W-1:0];
        geom_next.len2  = {1'b0, sqx_b_reg} + {1'b0, sqy_b_reg};
        geom_next.vx    = cpos ? dy_b_reg : DIFF_W'(-dy_b_reg);
        geom_next.vy    = cpos ? DIFF_W'(-dx_b_reg) : dx_b_reg;
        geom_next.degen = degen_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_a_reg    <= {item.second_x[COORD_BITS-1], item.second_x}
                       - {item.first_x[COORD_BITS-1], item.first_x};
        dy_a_reg    <= {item.second_y[COORD_BITS-1], item.second_y}
                       - {item.first_y[COORD_BITS-1], item.first_y};
        p0_a_reg    <= p0_next;
        p1_a_reg    <= p1_next;
        degen_a_reg <= (item.first_x == item.second_x) && (item.first_y == item.second_y);

        dx_b_reg    <= dx_a_reg;
        dy_b_reg    <= dy_a_reg;
        cross_b_reg <= {p0_a_reg[PROD_W-1], p0_a_reg} - {p1_a_reg[PROD_W-1], p1_a_reg};
        sqx_b_reg   <= sqx_full[PROD_W-1:0];
        sqy_b_reg   <= sqy_full[PROD_W-1:0];
        degen_b_reg <= degen_a_reg;

        geom_reg    <= geom_next;
    end

    assign geom_valid = valid_reg[2];
    assign geom       = geom_reg;

endmodule

// File: rtl/core/lnf_dist.sv
// Distance unit: rounded |cross| / |P1 - P0| found one result bit per stage
// by shift-and-add updates of the residual. Depends on lnf_pkg.
module lnf_dist (
    input  logic                          clk,
    input  logic [lnf_pkg::CMAG_W-1:0]    cmag,
    input  logic [lnf_pkg::L2_W-1:0]      len2,
    output logic [lnf_pkg::DIST_BITS-1:0] distance
);
    import lnf_pkg::*;

    logic [RSQ_W-1:0]         rsq_reg;
    logic [L2_W-1:0]          len2_reg;
    logic signed [DIST_W-1:0] e_reg  [COORD_BITS];
    logic signed [DIST_W-1:0] g_reg  [COORD_BITS];
    logic signed [DIST_W-1:0] l2_reg [COORD_BITS-1];
    logic [DIST_BITS-1:0]     d_reg  [COORD_BITS];

    logic [RSQ_W-1:0]         rsq_next;
    logic signed [DIST_W-1:0] l2_ext;

    assign rsq_next = cmag * cmag;
    assign l2_ext   = $signed({{(DIST_W-L2_W){1'b0}}, len2_reg});

    always_ff @(posedge clk)
    begin
        rsq_reg   <= rsq_next;
        len2_reg  <= len2;
        // residual 4*cross^2 - len2 for d = 0, slope (2^(top bit) - 1) * len2
        e_reg[0]  <= $signed({{(DIST_W-RSQ_W-2){1'b0}}, rsq_reg, 2'b00}) - l2_ext;
        g_reg[0]  <= (l2_ext <<< (COORD_BITS-1)) - l2_ext;
        l2_reg[0] <= l2_ext;
    end

    for (genvar j = 0; j < COORD_BITS; j++)
    begin : g_step
        localparam int B = COORD_BITS - 1 - j;
        logic signed [DIST_W-1:0] e_next;
        logic                     take;
        logic [DIST_BITS-1:0]     d_prev;

        assign e_next = e_reg[j] - (g_reg[j] <<< (B + 2));
        assign take   = ~e_next[DIST_W-1];

        if (j == 0)
        begin : g_first
            assign d_prev = '0;
        end
        else
        begin : g_rest
            assign d_prev = d_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            d_reg[j] <= d_prev | (DIST_BITS'(take) << B);
        end

        if (j < COORD_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                e_reg[j+1] <= take ? e_next : e_reg[j];
                g_reg[j+1] <= take ? g_reg[j] + (l2_reg[j] <<< B) + (l2_reg[j] <<< (B - 1))
                                   : g_reg[j] - (l2_reg[j] <<< (B - 1));
            end
        end

        if (j < COORD_BITS - 2)
        begin : g_len
            always_ff @(posedge clk)
            begin
                l2_reg[j+1] <= l2_reg[j];
            end
        end
    end

    assign distance = d_reg[COORD_BITS-1];

endmodule

// File: rtl/core/lnf_cordic.sv
// Vectoring CORDIC: four-quadrant angle of the normal, one step per stage,
// with valid and coincident-point flag carried alongside. Depends on lnf_pkg.
module lnf_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_degen,
    input  logic signed [lnf_pkg::DIFF_W-1:0]    vx,
    input  logic signed [lnf_pkg::DIFF_W-1:0]    vy,
    output logic                                 out_valid,
    output logic                                 out_degen,
    output logic signed [lnf_pkg::ANGLE_BITS-1:0] angle
);
    import lnf_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]      z_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS+1:0]    valid_reg;
    logic                       dg_reg [CORDIC_STEPS+2];
    logic signed [ANGLE_BITS-1:0] angle_reg;

    logic signed [CORDIC_W-1:0] xs, ys, x_next, y_next;
    logic signed [Z_W-1:0]      z_next, z_round;
    logic signed [Z_W-1:0]      z_shift;

    always_comb
    begin
        xs = CORDIC_W'(vx) <<< CORDIC_SHIFT;
        ys = CORDIC_W'(vy) <<< CORDIC_SHIFT;
        x_next = xs;
        y_next = ys;
        z_next = '0;
        // fold the left half-plane onto the right with a quarter turn
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x_next = ys;
                y_next = -xs;
                z_next = Z_W'(1) <<< 30;
            end
            else
            begin
                x_next = -ys;
                y_next = xs;
                z_next = -(Z_W'(1) <<< 30);
            end
        end
        z_round = z_reg[CORDIC_STEPS] + (Z_W'(1) <<< (ANGLE_SHIFT - 1));
        z_shift = z_round >>> ANGLE_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[CORDIC_STEPS:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]  <= x_next;
        y_reg[0]  <= y_next;
        z_reg[0]  <= z_next;
        dg_reg[0] <= in_degen;
        angle_reg <= z_shift[ANGLE_BITS-1:0];
        dg_reg[CORDIC_STEPS+1] <= dg_reg[CORDIC_STEPS];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [CORDIC_W-1:0] xsh, ysh;
        logic signed [Z_W-1:0]      at;

        assign xsh = x_reg[i] >>> i;
        assign ysh = y_reg[i] >>> i;
        assign at  = $signed({{(Z_W-32){1'b0}}, ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + ysh;
                y_reg[i+1] <= y_reg[i] - xsh;
                z_reg[i+1] <= z_reg[i] + at;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ysh;
                y_reg[i+1] <= y_reg[i] + xsh;
                z_reg[i+1] <= z_reg[i] - at;
            end
            dg_reg[i+1] <= dg_reg[i];
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS+1];
    assign out_degen = dg_reg[CORDIC_STEPS+1];
    assign angle     = angle_reg;

endmodule

// File: rtl/core/line_normal_form_from_two_points.sv
// Top level of the two-point line normal form block.
// Instantiates lnf_front, lnf_dist and lnf_cordic; depends on lnf_pkg.
//
// Takes one point pair on every clock at which start is high; busy is always
// low. Each pair gives one result, shown for one cycle with done high, after
// the 3 front stages (differences, products, sums), the angle stages
// (quarter-turn fold, 30 CORDIC steps, rounding) and one output register.
// The distance unit (one result bit per stage) is shorter than the angle path
// and its answer waits in a short delay line. The receiver cannot
// stall, so nothing holds the pipeline; results leave in order of arrival.
module line_normal_form_from_two_points (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lnf_pkg::lnf_item_t   item,
    output logic                 done,
    output lnf_pkg::lnf_result_t result
);
    import lnf_pkg::*;

    localparam int DLY = CORDIC_LAT - DIST_LAT;

    logic                         geom_valid;
    lnf_geom_t                    geom;
    logic [DIST_BITS-1:0]         dist_val;
    logic                         ang_valid, ang_degen;
    logic signed [ANGLE_BITS-1:0] ang;
    logic [DIST_BITS-1:0]         dly_reg [DLY];
    logic                         done_reg;
    lnf_result_t                  result_reg;
    lnf_result_t                  result_next;

    lnf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .item       (item),
        .geom_valid (geom_valid),
        .geom       (geom)
    );

    lnf_dist u_dist (
        .clk      (clk),
        .cmag     (geom.cmag),
        .len2     (geom.len2),
        .distance (dist_val)
    );

    lnf_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_degen  (geom.degen),
        .vx        (geom.vx),
        .vy        (geom.vy),
        .out_valid (ang_valid),
        .out_degen (ang_degen),
        .angle     (ang)
    );

    // hold the distance until the angle of the same pair is ready
    always_ff @(posedge clk)
    begin
        dly_reg[0] <= dist_val;
        for (int k = 1; k < DLY; k++)
        begin
            dly_reg[k] <= dly_reg[k-1];
        end
    end

    always_comb
    begin
        result_next.degenerate   = ang_degen;
        result_next.distance     = ang_degen ? '0 : dly_reg[DLY-1];
        result_next.normal_angle = ang_degen ? '0 : ang;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ang_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/lnf_checker.sv
// Port-level checks for line_normal_form_from_two_points, bound to the top.
// Depends on lnf_pkg.
module lnf_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input lnf_pkg::lnf_result_t result
);
    import lnf_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL_LAT done)
        else $error("transfer without result at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result without a matching transfer");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |-> (result.distance == '0 && result.normal_angle == '0))
        else $error("coincident points gave non-zero outputs");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.distance <= DIST_BITS'(DIST_MAX)))
        else $error("distance out of range");

endmodule

bind line_normal_form_from_two_points lnf_checker u_lnf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: bench/tb_top.sv
// Testbench for the two-point line normal form block: directed table, then random pairs.
// Predicts (or takes from the table) distance, normal angle and degenerate flag per transfer; depends on lnf_pkg.
module tb_top;
    import lnf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 950;

    typedef struct {
        lnf_item_t   pts;
        logic        fixed;
        lnf_result_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    lnf_item_t   item;
    logic        done;
    lnf_result_t result;

    lnf_result_t expected_lines[$];
    int          n_errors;
    int          idle_cycles;
    row_t        table_rows[$];

    line_normal_form_from_two_points uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .item(item), .done(done), .result(result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint fshift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic lnf_result_t predict_line(lnf_item_t p);
        lnf_result_t r;
        longint x0, y0, x1, y1, dx, dy, cr, s, x, y, z, ox, xs, ys;
        logic [63:0] cmag, len2, d, t, a;
        logic [127:0] rhs, lhs;
        int k;
        x0 = p.first_x;
        y0 = p.first_y;
        x1 = p.second_x;
        y1 = p.second_y;
        dx = x1 - x0;
        dy = y1 - y0;
        k = 32 - ANGLE_BITS;
        r = '0;
        if (dx == 0 && dy == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        cr = x0 * y1 - y0 * x1;
        cmag = (cr < 0) ? -cr : cr;
        s = (cr > 0) ? 1 : -1;
        len2 = dx * dx + dy * dy;
        rhs = (2 * cmag) * (2 * cmag);
        d = 0;
        for (int b = COORD_BITS - 1; b >= 0; b--)
        begin
            t = d | (64'd1 << b);
            a = 2 * t - 1;
            lhs = 128'(a * a) * 128'(len2);
            if (lhs <= rhs)
                d = t;
        end
        x = (s * dy) * (longint'(1) << (40 - COORD_BITS));
        y = (-s * dx) * (longint'(1) << (40 - COORD_BITS));
        z = 0;
        if (x < 0)
        begin
            ox = x;
            if (y >= 0)
            begin
                x = y; y = -ox; z = longint'(1) << 30;
            end
            else
            begin
                x = -y; y = ox; z = -(longint'(1) << 30);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
            end
            else
            begin
                x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
            end
        end
        r.distance = d[DIST_BITS-1:0];
        r.normal_angle = ANGLE_BITS'(fshift(z + (longint'(1) << (k - 1)), k));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_lines.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                lnf_result_t e;
                e = expected_lines.pop_front();
                if (result.distance !== e.distance)
                    report_mismatch("distance", result.distance, e.distance);
                if (result.normal_angle !== e.normal_angle)
                    report_mismatch("normal_angle", result.normal_angle, e.normal_angle);
                if (result.degenerate !== e.degenerate)
                    report_mismatch("degenerate", result.degenerate, e.degenerate);
            end
        end
    end

    // watchdog: count cycles with no transfer either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic lnf_item_t mk(int a, int b, int c, int d);
        lnf_item_t p;
        p.first_x  = COORD_BITS'(a);
        p.first_y  = COORD_BITS'(b);
        p.second_x = COORD_BITS'(c);
        p.second_y = COORD_BITS'(d);
        return p;
    endfunction

    function automatic lnf_result_t res(int dist_code, int ang, bit dg);
        lnf_result_t r;
        r.distance     = DIST_BITS'(dist_code);
        r.normal_angle = ANGLE_BITS'(ang);
        r.degenerate   = dg;
        return r;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pair(lnf_item_t p, lnf_result_t e);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_lines.push_back(e);
    endtask

    initial
    begin
        lnf_item_t p;
        int c;
        n_errors = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        // coincident points, line through origin, extremes, +pi wrap
        table_rows.push_back('{mk(0, 0, 0, 0), 1, res(0, 0, 1)});
        table_rows.push_back('{mk(-32768, 32767, -32768, 32767), 1, res(0, 0, 1)});
        table_rows.push_back('{mk(10, 0, 10, 5), 1, res(10, 0, 0)});
        table_rows.push_back('{mk(0, 0, 100, 100), 0, '0});
        table_rows.push_back('{mk(-32768, -32768, 32767, 32767), 0, '0});
        table_rows.push_back('{mk(-32768, 32767, 32767, -32768), 0, '0});
        table_rows.push_back('{mk(-32768, -32768, 32767, -32768), 0, '0});
        table_rows.push_back('{mk(32767, -32768, 32767, 32767), 0, '0});
        table_rows.push_back('{mk(-32768, 32767, 32767, 32767), 0, '0});
        table_rows.push_back('{mk(-10, 0, -10, 5), 0, '0});
        table_rows.push_back('{mk(0, -7, 5, -7), 0, '0});
        table_rows.push_back('{mk(0, 7, 5, 7), 0, '0});
        table_rows.push_back('{mk(5, 0, 0, 0), 0, '0});
        table_rows.push_back('{mk(1, 0, 0, 1), 0, '0});
        table_rows.push_back('{mk(-1, 0, 0, -1), 0, '0});
        table_rows.push_back('{mk(3, 4, 4, 3), 0, '0});
        table_rows.push_back('{mk(-32768, 0, 0, -32768), 0, '0});
        table_rows.push_back('{mk(32767, 0, 0, 32767), 0, '0});
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
            send_pair(table_rows[i].pts,
                      table_rows[i].fixed ? table_rows[i].res
                                          : predict_line(table_rows[i].pts));
        for (int n = 0; n < N_RANDOM; n++)
        begin
            c = $urandom_range(0, 19);
            p.first_x = rand_coord();
            p.first_y = rand_coord();
            if (c == 0)
            begin
                p.second_x = p.first_x;
                p.second_y = p.first_y;
            end
            else if (c == 1)
            begin
                // mirror the first point to aim the line at the origin
                p.second_x = -p.first_x;
                p.second_y = -p.first_y;
            end
            else
            begin
                p.second_x = rand_coord();
                p.second_y = rand_coord();
            end
            send_pair(p, predict_line(p));
        end
        start <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 4) @(posedge clk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
